FILE: design/decimal_number_tile_render_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal number tile renderer
// Concurrent checks on clk, disabled while rst_n is low; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_NUMBER_TILE_RENDER_DEFINES_SVH
`define DECIMAL_NUMBER_TILE_RENDER_DEFINES_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define DNTR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define DNTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DNTR_ASSERT_SAME(lbl, ante, cons)
`define DNTR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: design/dntr_pkg.sv
// ----------------------------------------------------------------------------
// dntr_pkg
// Types and constants of the decimal number tile renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package dntr_pkg;

  localparam int MAX_DIGITS  = 16;
  localparam int VALUE_W     = 32;
  localparam int BCD_DIGITS  = 10;   // decimal digits of a 32-bit value
  localparam int WIDTH_W     = 5;
  localparam int CODE_W      = 8;
  localparam int COL_W       = 6;
  localparam int ROW_W       = 5;
  localparam int POS_W       = $clog2(MAX_DIGITS);
  localparam int CNT_W       = $clog2(VALUE_W);
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 24;

  localparam logic [CODE_W-1:0] RESET_DIGIT_BASE = 8'd43;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_PREP,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: design/decimal_number_tile_render.sv
// ----------------------------------------------------------------------------
// decimal_number_tile_render
// Bit-serial binary to decimal conversion, then one cell write per field position.
// ----------------------------------------------------------------------------
//  channel | dir | payload (low bits first)
//  in_     | in  | tdata: number_value, field_width, pad_code, start_column,
//          |     |        text_row
//  out_    | out | tdata: cell_column, cell_row, tile_code; tlast: last_cell
//  cfg_    | in  | wdata: digit_base, written when cfg_wr_en is high
//
//  An item runs a shift-and-adjust conversion (one value bit per cycle),
//  then a setup state, then one cell write per field position, leftmost
//  column first. No new request is taken while an item is in progress:
//  the next request is taken once the last cell sits in the output
//  register. Output stalls hold the cell sequence. Reset is synchronous
//  and sets digit_base to 43.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_number_tile_render_defines.svh"

module decimal_number_tile_render (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // number_value[31:0], field_width[36:32], pad_code[44:37],
  // start_column[50:45], text_row[55:51]
  input  wire logic [dntr_pkg::IN_DATA_W-1:0]     in_tdata,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // cell_column[5:0], cell_row[10:6], tile_code[18:11], zero fill above
  output      logic [dntr_pkg::OUT_DATA_W-1:0]    out_tdata,
  output      logic                               out_tlast,
  input  wire logic                               cfg_wr_en,
  input  wire logic [dntr_pkg::CODE_W-1:0]        cfg_wdata
);

  dntr_pkg::state_t state_r, state_nxt;

  logic [dntr_pkg::CODE_W-1:0]                   base_r;
  logic [dntr_pkg::VALUE_W-1:0]                  bin_r, bin_nxt;
  logic [dntr_pkg::BCD_DIGITS-1:0][3:0]          bcd_r, bcd_nxt, bcd_adj;
  logic [4*dntr_pkg::BCD_DIGITS-1:0]             bcd_adj_flat;
  logic [dntr_pkg::CNT_W-1:0]                    cnt_r, cnt_nxt;
  logic [dntr_pkg::WIDTH_W-1:0]                  width_r, width_nxt;
  logic [dntr_pkg::CODE_W-1:0]                   pad_r, pad_nxt;
  logic [dntr_pkg::COL_W-1:0]                    col_r, col_nxt;
  logic [dntr_pkg::ROW_W-1:0]                    row_r, row_nxt;
  logic [dntr_pkg::POS_W-1:0]                    pos_r, pos_nxt;
  logic                                          started_r, started_nxt;

  logic                                          out_valid_r, out_valid_nxt;
  logic                                          out_last_r, out_last_nxt;
  logic [dntr_pkg::COL_W-1:0]                    out_col_r, out_col_nxt;
  logic [dntr_pkg::ROW_W-1:0]                    out_row_r, out_row_nxt;
  logic [dntr_pkg::CODE_W-1:0]                   out_code_r, out_code_nxt;

  logic [dntr_pkg::WIDTH_W-1:0]                  in_width;
  logic [dntr_pkg::WIDTH_W-1:0]                  width_clamped;
  logic                                          slot_free;
  logic [3:0]                                    digit;
  logic                                          show;
  logic                                          high_nz;
  logic                                          conv_done;
  logic                                          emit_last;

  assign in_width   = in_tdata[36:32];
  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == dntr_pkg::S_IDLE);
  assign conv_done  = (state_r == dntr_pkg::S_CONV) &&
                      (cnt_r == dntr_pkg::CNT_W'(dntr_pkg::VALUE_W - 1));
  assign emit_last  = (state_r == dntr_pkg::S_EMIT) && slot_free && (pos_r == '0);

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_code_r, out_row_r, out_col_r};

  always_comb begin
    if (in_width == '0) begin
      width_clamped = dntr_pkg::WIDTH_W'(1);
    end else if (in_width > dntr_pkg::WIDTH_W'(dntr_pkg::MAX_DIGITS)) begin
      width_clamped = dntr_pkg::WIDTH_W'(dntr_pkg::MAX_DIGITS);
    end else begin
      width_clamped = in_width;
    end
  end

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int j = 0; j < dntr_pkg::BCD_DIGITS; j++) begin
      bcd_adj[j] = (bcd_r[j] >= 4'd5) ? bcd_r[j] + 4'd3 : bcd_r[j];
    end
  end

  assign bcd_adj_flat = bcd_adj;

  // digits dropped by truncation still make leading zeros significant
  always_comb begin
    high_nz = 1'b0;
    for (int j = 0; j < dntr_pkg::BCD_DIGITS; j++) begin
      if ((bcd_r[j] != 4'd0) && (dntr_pkg::WIDTH_W'(j) >= width_r)) begin
        high_nz = 1'b1;
      end
    end
  end

  always_comb begin
    if (pos_r < dntr_pkg::POS_W'(dntr_pkg::BCD_DIGITS)) begin
      digit = bcd_r[pos_r];
    end else begin
      digit = 4'd0;
    end
    show = started_r || (digit != 4'd0) || (pos_r == '0);
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    width_nxt     = width_r;
    pad_nxt       = pad_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pos_nxt       = pos_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_code_nxt  = out_code_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      dntr_pkg::S_IDLE: begin
        if (in_tvalid) begin
          bin_nxt   = in_tdata[31:0];
          width_nxt = width_clamped;
          pad_nxt   = in_tdata[44:37];
          col_nxt   = in_tdata[50:45];
          row_nxt   = in_tdata[55:51];
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = dntr_pkg::S_CONV;
        end
      end
      dntr_pkg::S_CONV: begin
        bcd_nxt = {bcd_adj_flat[4*dntr_pkg::BCD_DIGITS-2:0], bin_r[dntr_pkg::VALUE_W-1]};
        bin_nxt = {bin_r[dntr_pkg::VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (conv_done) begin
          state_nxt = dntr_pkg::S_PREP;
        end
      end
      dntr_pkg::S_PREP: begin
        started_nxt = high_nz;
        pos_nxt     = dntr_pkg::POS_W'(width_r - 1'b1);
        state_nxt   = dntr_pkg::S_EMIT;
      end
      dntr_pkg::S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (pos_r == '0);
          out_col_nxt   = col_r;
          out_row_nxt   = row_r;
          out_code_nxt  = show ? base_r + {4'd0, digit} : pad_r;
          started_nxt   = show;
          col_nxt       = col_r + 1'b1;
          pos_nxt       = pos_r - 1'b1;
          if (pos_r == '0) begin
            state_nxt = dntr_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = dntr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dntr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= dntr_pkg::RESET_DIGIT_BASE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    width_r    <= width_nxt;
    pad_r      <= pad_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    pos_r      <= pos_nxt;
    started_r  <= started_nxt;
    out_last_r <= out_last_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_code_r <= out_code_nxt;
  end

  // a request starts a fresh 32-step conversion
  `DNTR_ASSERT_NEXT(a_start_conv, in_tvalid && in_tready, (state_r == dntr_pkg::S_CONV) && (cnt_r == '0))
  // conversion ends after exactly the last value bit
  `DNTR_ASSERT_NEXT(a_conv_done, conv_done, state_r == dntr_pkg::S_PREP)
  // cell position stays inside the field
  `DNTR_ASSERT_SAME(a_pos_range, state_r == dntr_pkg::S_EMIT, {1'b0, pos_r} < width_r)
  // loading the rightmost cell marks it last and frees the input
  `DNTR_ASSERT_NEXT(a_last_cell, emit_last, out_valid_r && out_last_r && in_tready)

endmodule

`default_nettype wire
